/* design/plm_pkg.sv */
// Package for the pooled linked list manager: sizes, codes, command/status structs.
// No dependencies.
package plm_pkg;
  localparam int unsigned NODES  = 64;
  localparam int unsigned LISTS  = 16;
  localparam int unsigned ITEM_W = 32;
  localparam int unsigned NW = $clog2(NODES) + 1;  // node ref incl. null bit
  localparam int unsigned NA = $clog2(NODES);
  localparam int unsigned LW = $clog2(LISTS) + 1;
  localparam int unsigned LA = $clog2(LISTS);
  localparam int unsigned CW = $clog2(NODES + 1);

  localparam logic [NW-1:0] NIL = {NW{1'b1}};

  localparam logic [1:0] POS_ON     = 2'd0;
  localparam logic [1:0] POS_BEYOND = 2'd1;
  localparam logic [1:0] POS_BEFORE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_DEAD = 2'd3;

  localparam logic [3:0] F_CREATE = 4'd0;
  localparam logic [3:0] F_COUNT  = 4'd1;
  localparam logic [3:0] F_FIRST  = 4'd2;
  localparam logic [3:0] F_LAST   = 4'd3;
  localparam logic [3:0] F_NEXT   = 4'd4;
  localparam logic [3:0] F_PREV   = 4'd5;
  localparam logic [3:0] F_CURR   = 4'd6;
  localparam logic [3:0] F_ADD    = 4'd7;
  localparam logic [3:0] F_INSERT = 4'd8;
  localparam logic [3:0] F_APPEND = 4'd9;
  localparam logic [3:0] F_PREPND = 4'd10;
  localparam logic [3:0] F_REMOVE = 4'd11;
  localparam logic [3:0] F_CONCAT = 4'd12;
  localparam logic [3:0] F_FREE   = 4'd13;
  localparam logic [3:0] F_TRIM   = 4'd14;
  localparam logic [3:0] F_SEARCH = 4'd15;

  // node-pool memory ops requested by the controller
  typedef struct packed {
    logic          rd_en;     // read fwd/back/value at rd_addr
    logic [NA-1:0] rd_addr;
    logic          fw_en;
    logic [NA-1:0] fw_addr;
    logic [NW-1:0] fw_data;
    logic          bw_en;
    logic [NA-1:0] bw_addr;
    logic [NW-1:0] bw_data;
    logic          val_en;
    logic [NA-1:0] val_addr;
  } pool_cmd_t;

  typedef struct packed {
    logic [NW-1:0]     fwd;
    logic [NW-1:0]     bwd;
    logic [ITEM_W-1:0] value;
    logic              match;
  } pool_sts_t;
endpackage

/* design/pooled_linked_list_manager.sv */
// Top level: pooled doubly linked list manager. Op accepted when start && !busy.
// Search walks one node a cycle from the cursor; a create with no live list first rebuilds
// the node pool.
// One op at a time, next accept in the cycle after the result strobe; the receiver cannot stall.
// Reset (async, active low): all lists dead, list free stack chained, mask all ones.
module pooled_linked_list_manager (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  func_i,
  input  logic [3:0]  list_id_i,
  input  logic [3:0]  other_list_id_i,
  input  logic [31:0] item_i,
  input  logic [31:0] search_key_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        strobe_o,
  output logic [1:0]  status_o,
  output logic [31:0] item_out_o,
  output logic [6:0]  count_out_o,
  output logic [3:0]  new_list_o
);
  import plm_pkg::*;
  pool_cmd_t   cmd;
  pool_sts_t   sts;
  logic [ITEM_W-1:0] wval, mask_q, key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mask_q <= '1;
    else if (cfg_we_i) mask_q <= cfg_wdata_i;
  end
  always_ff @(posedge clk_i) if (start && !busy) key_q <= search_key_i;

  plm_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .func_i, .list_id_i,
    .other_list_id_i, .item_i, .cmd_o(cmd), .wval_o(wval), .sts_i(sts),
    .done_o(strobe_o), .status_o, .item_out_o, .count_out_o, .new_list_o);

  plm_pool u_pool (.clk_i, .cmd_i(cmd), .wval_i(wval), .key_i(key_q), .mask_i(mask_q),
    .sts_o(sts));
endmodule

/* design/plm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[raddr_i];
  end
endmodule

/* design/plm_pool.sv */
// Node pool datapath: value, forward and backward RAMs plus masked compare.
// Depends on plm_pkg and plm_ram.
module plm_pool (
  input  logic                      clk_i,
  input  plm_pkg::pool_cmd_t        cmd_i,
  input  logic [plm_pkg::ITEM_W-1:0] wval_i,
  input  logic [plm_pkg::ITEM_W-1:0] key_i,
  input  logic [plm_pkg::ITEM_W-1:0] mask_i,
  output plm_pkg::pool_sts_t        sts_o
);
  import plm_pkg::*;
  logic [NW-1:0]     fwd, bwd;
  logic [ITEM_W-1:0] val;

  plm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fwd (
    .clk_i, .we_i(cmd_i.fw_en), .waddr_i(cmd_i.fw_addr), .wdata_i(cmd_i.fw_data),
    .re_i(cmd_i.rd_en), .raddr_i(cmd_i.rd_addr), .rdata_o(fwd));
  plm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_bwd (
    .clk_i, .we_i(cmd_i.bw_en), .waddr_i(cmd_i.bw_addr), .wdata_i(cmd_i.bw_data),
    .re_i(cmd_i.rd_en), .raddr_i(cmd_i.rd_addr), .rdata_o(bwd));
  plm_ram #(.WIDTH(ITEM_W), .DEPTH(NODES)) u_val (
    .clk_i, .we_i(cmd_i.val_en), .waddr_i(cmd_i.val_addr), .wdata_i(wval_i),
    .re_i(cmd_i.rd_en), .raddr_i(cmd_i.rd_addr), .rdata_o(val));

  always_comb begin
    sts_o.fwd   = fwd;
    sts_o.bwd   = bwd;
    sts_o.value = val;
    sts_o.match = ((val ^ key_i) & mask_i) == '0;
  end
endmodule

/* design/plm_ctrl.sv */
// Controller: list heads, free stacks and the operation sequencer.
// Depends on plm_pkg; drives plm_pool through pool_cmd_t.
module plm_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [3:0]                 func_i,
  input  logic [3:0]                 list_id_i,
  input  logic [3:0]                 other_list_id_i,
  input  logic [plm_pkg::ITEM_W-1:0] item_i,
  output plm_pkg::pool_cmd_t         cmd_o,
  output logic [plm_pkg::ITEM_W-1:0] wval_o,
  input  plm_pkg::pool_sts_t         sts_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [plm_pkg::ITEM_W-1:0] item_out_o,
  output logic [6:0]                 count_out_o,
  output logic [3:0]                 new_list_o
);
  import plm_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;  // rebuild node free stack, one node a cycle
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_RD1    = 4'd3;  // pool read data available
  localparam logic [3:0] S_ALLOC  = 4'd4;  // neighbor link fixes, or freed-node push after unlink
  localparam logic [3:0] S_LINK   = 4'd5;  // take free top's forward link, write new node
  localparam logic [3:0] S_UNL    = 4'd6;  // cursor node read done, unlink
  localparam logic [3:0] S_SRCH   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state_q, state_d;

  logic [NW-1:0] first_q [LISTS], first_d [LISTS];
  logic [NW-1:0] last_q  [LISTS], last_d  [LISTS];
  logic [NW-1:0] cur_q   [LISTS], cur_d   [LISTS];
  logic [CW-1:0] size_q  [LISTS], size_d  [LISTS];
  logic [1:0]    pos_q   [LISTS], pos_d   [LISTS];
  logic [LISTS-1:0] live_q, live_d;
  logic [LW-1:0] hlink_q [LISTS], hlink_d [LISTS];
  logic [NW-1:0] ftop_q, ftop_d;
  logic [LW-1:0] htop_q, htop_d;
  logic [LW-1:0] lused_q, lused_d;
  logic [NA:0]   icnt_q, icnt_d;

  logic [3:0]        fn_q, fn_d;
  logic [LA-1:0]     l_q, l_d, l2_q, l2_d;
  logic [ITEM_W-1:0] val_q, val_d;
  // mode for allocation: 0 append,1 prepend,2 add-after,3 insert-before
  logic [1:0]        amode_q, amode_d;
  logic [NW-1:0]     nb_q, nb_d;      // neighbor for add/insert
  logic [NW-1:0]     walk_q, walk_d;
  logic [NA:0]       steps_q, steps_d;
  logic [1:0]        rst_q, rst_d;
  logic [ITEM_W-1:0] rit_q, rit_d;
  logic [3:0]        rnl_q, rnl_d;
  logic              trim_q, trim_d;

  logic [NW-1:0] c;
  logic          cvalid;

  assign busy_o = state_q != S_IDLE;
  assign wval_o = val_q;
  assign c      = cur_q[l_q];
  assign cvalid = !c[NW-1];

  always_comb begin
    state_d = state_q;
    first_d = first_q; last_d = last_q; cur_d = cur_q; size_d = size_q;
    pos_d = pos_q; live_d = live_q; hlink_d = hlink_q;
    ftop_d = ftop_q; htop_d = htop_q; lused_d = lused_q; icnt_d = icnt_q;
    fn_d = fn_q; l_d = l_q; l2_d = l2_q; val_d = val_q; amode_d = amode_q;
    nb_d = nb_q; walk_d = walk_q; steps_d = steps_q;
    rst_d = rst_q; rit_d = rit_q; rnl_d = rnl_q; trim_d = trim_q;
    cmd_o = '0;
    done_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          fn_d = func_i;
          l_d = list_id_i[LA-1:0];
          l2_d = other_list_id_i[LA-1:0];
          val_d = item_i;
          rst_d = ST_OK; rit_d = '0; rnl_d = '0; trim_d = 1'b0;
          if (func_i == F_CREATE && lused_q == '0) begin
            icnt_d = '0;
            state_d = S_INIT;
          end else begin
            state_d = S_DISP;
          end
        end
      end
      S_INIT: begin
        cmd_o.fw_en = 1'b1;
        cmd_o.fw_addr = icnt_q[NA-1:0];
        cmd_o.fw_data = (icnt_q == (NA+1)'(NODES - 1)) ? NIL : NW'(icnt_q + 1'b1);
        cmd_o.bw_en = 1'b1;
        cmd_o.bw_addr = icnt_q[NA-1:0];
        cmd_o.bw_data = NIL;
        icnt_d = icnt_q + 1'b1;
        if (icnt_q == (NA+1)'(NODES - 1)) begin
          for (int i = 0; i < LISTS; i++)
            hlink_d[i] = (i + 1 < LISTS) ? LW'(i + 1) : {LW{1'b1}};
          ftop_d = '0; htop_d = '0;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_DONE;
        if (fn_q == F_CREATE) begin
          if (htop_q[LW-1]) rst_d = ST_FULL;
          else begin
            htop_d = hlink_q[htop_q[LA-1:0]];
            first_d[htop_q[LA-1:0]] = NIL; last_d[htop_q[LA-1:0]] = NIL;
            cur_d[htop_q[LA-1:0]] = NIL; size_d[htop_q[LA-1:0]] = '0;
            pos_d[htop_q[LA-1:0]] = POS_ON;
            live_d[htop_q[LA-1:0]] = 1'b1;
            lused_d = lused_q + 1'b1;
            rnl_d = 4'(htop_q[LA-1:0]);
          end
        end else if (!live_q[l_q] || (fn_q == F_CONCAT && !live_q[l2_q])) begin
          rst_d = ST_DEAD;
        end else begin
          case (fn_q)
            F_COUNT: ;
            F_FIRST, F_LAST: begin
              nb_d = (fn_q == F_FIRST) ? first_q[l_q] : last_q[l_q];
              if (size_q[l_q] == '0 || nb_d[NW-1]) rst_d = ST_NONE;
              else begin
                cur_d[l_q] = nb_d; pos_d[l_q] = POS_ON;
                cmd_o.rd_en = 1'b1; cmd_o.rd_addr = nb_d[NA-1:0];
                state_d = S_RD1;
              end
            end
            F_NEXT, F_PREV, F_CURR, F_REMOVE: begin
              if (!cvalid) rst_d = ST_NONE;
              else if ((fn_q == F_CURR || fn_q == F_REMOVE) &&
                       (pos_q[l_q] != POS_ON || size_q[l_q] == '0)) rst_d = ST_NONE;
              else begin
                cmd_o.rd_en = 1'b1; cmd_o.rd_addr = c[NA-1:0];
                state_d = (fn_q == F_REMOVE) ? S_UNL : S_RD1;
              end
            end
            F_TRIM: begin
              if (size_q[l_q] == '0 || last_q[l_q][NW-1]) rst_d = ST_NONE;
              else begin
                cur_d[l_q] = last_q[l_q]; pos_d[l_q] = POS_ON; trim_d = 1'b1;
                cmd_o.rd_en = 1'b1; cmd_o.rd_addr = last_q[l_q][NA-1:0];
                state_d = S_UNL;
              end
            end
            F_ADD, F_INSERT, F_APPEND, F_PREPND: begin
              if (ftop_q[NW-1]) rst_d = ST_FULL;
              else begin
                if (fn_q == F_APPEND) amode_d = 2'd0;
                else if (fn_q == F_PREPND) amode_d = 2'd1;
                else if (pos_q[l_q] == POS_BEYOND) amode_d = 2'd0;
                else if (pos_q[l_q] == POS_BEFORE) amode_d = 2'd1;
                else if (size_q[l_q] == '0 || !cvalid) amode_d = 2'd0;
                else amode_d = (fn_q == F_ADD) ? 2'd2 : 2'd3;
                if (amode_d == 2'd1 && (size_q[l_q] == '0 || first_q[l_q][NW-1]))
                  amode_d = 2'd0;
                // cursor links needed for add/insert; reuse RD1 to fetch them
                if (amode_d[1]) begin
                  cmd_o.rd_en = 1'b1; cmd_o.rd_addr = c[NA-1:0];
                  state_d = S_RD1;
                end else begin
                  cmd_o.rd_en = 1'b1; cmd_o.rd_addr = ftop_q[NA-1:0];
                  state_d = S_LINK;
                end
              end
            end
            F_CONCAT: begin
              if (l2_q == l_q) rst_d = ST_NONE;
              else begin
                if (size_q[l2_q] != '0) begin
                  if (size_q[l_q] == '0) begin
                    first_d[l_q] = first_q[l2_q]; last_d[l_q] = last_q[l2_q];
                    cur_d[l_q] = cur_q[l2_q]; size_d[l_q] = size_q[l2_q];
                    pos_d[l_q] = pos_q[l2_q];
                  end else begin
                    if (!last_q[l_q][NW-1]) begin
                      cmd_o.fw_en = 1'b1; cmd_o.fw_addr = last_q[l_q][NA-1:0];
                      cmd_o.fw_data = first_q[l2_q];
                    end
                    if (!first_q[l2_q][NW-1]) begin
                      cmd_o.bw_en = 1'b1; cmd_o.bw_addr = first_q[l2_q][NA-1:0];
                      cmd_o.bw_data = last_q[l_q];
                    end
                    last_d[l_q] = last_q[l2_q];
                    size_d[l_q] = size_q[l_q] + size_q[l2_q];
                    if (pos_q[l_q] == POS_BEYOND) cur_d[l_q] = last_q[l2_q];
                  end
                end
                first_d[l2_q] = NIL; last_d[l2_q] = NIL; cur_d[l2_q] = NIL;
                size_d[l2_q] = '0; pos_d[l2_q] = POS_ON; live_d[l2_q] = 1'b0;
                hlink_d[l2_q] = htop_q; htop_d = LW'(l2_q);
                lused_d = lused_q - 1'b1;
              end
            end
            F_FREE: begin
              if (size_q[l_q] != '0 && !last_q[l_q][NW-1]) begin
                cmd_o.fw_en = 1'b1; cmd_o.fw_addr = last_q[l_q][NA-1:0];
                cmd_o.fw_data = ftop_q;
                ftop_d = first_q[l_q];
              end
              first_d[l_q] = NIL; last_d[l_q] = NIL; cur_d[l_q] = NIL;
              size_d[l_q] = '0; pos_d[l_q] = POS_ON; live_d[l_q] = 1'b0;
              hlink_d[l_q] = htop_q; htop_d = LW'(l_q);
              lused_d = lused_q - 1'b1;
            end
            default: begin  // search
              if (!cvalid || pos_q[l_q] == POS_BEYOND) rst_d = ST_NONE;
              else begin
                walk_d = c; steps_d = '0;
                cmd_o.rd_en = 1'b1; cmd_o.rd_addr = c[NA-1:0];
                state_d = S_SRCH;
              end
            end
          endcase
        end
      end
      S_RD1: begin
        state_d = S_DONE;
        case (fn_q)
          F_FIRST, F_LAST, F_CURR: rit_d = sts_i.value;
          F_NEXT, F_PREV: begin
            nb_d = (fn_q == F_NEXT) ? sts_i.fwd : sts_i.bwd;
            if (pos_q[l_q] == POS_ON && !nb_d[NW-1]) begin
              cur_d[l_q] = nb_d;
              cmd_o.rd_en = 1'b1; cmd_o.rd_addr = nb_d[NA-1:0];
              fn_d = F_CURR;
              state_d = S_RD1;
            end else if (pos_q[l_q] == ((fn_q == F_NEXT) ? POS_BEFORE : POS_BEYOND)) begin
              pos_d[l_q] = POS_ON; rit_d = sts_i.value;
            end else begin
              pos_d[l_q] = (fn_q == F_NEXT) ? POS_BEYOND : POS_BEFORE;
              rst_d = ST_NONE;
            end
          end
          default: begin  // add / insert: cursor links fetched
            nb_d = (amode_q == 2'd2) ? sts_i.fwd : sts_i.bwd;
            if (nb_d[NW-1]) amode_d = (amode_q == 2'd2) ? 2'd0 : 2'd1;
            cmd_o.rd_en = 1'b1; cmd_o.rd_addr = ftop_q[NA-1:0];
            state_d = S_LINK;
          end
        endcase
      end
      S_LINK: begin
        // sts_i.fwd is the free top's link
        ftop_d = sts_i.fwd;
        cmd_o.val_en = 1'b1; cmd_o.val_addr = ftop_q[NA-1:0];
        cmd_o.fw_en = 1'b1; cmd_o.fw_addr = ftop_q[NA-1:0];
        cmd_o.bw_en = 1'b1; cmd_o.bw_addr = ftop_q[NA-1:0];
        // add/insert keep the old cursor until its link is fixed
        if (!amode_q[1]) cur_d[l_q] = ftop_q;
        size_d[l_q] = size_q[l_q] + 1'b1;
        state_d = S_ALLOC;
        case (amode_q)
          2'd0: begin
            cmd_o.fw_data = NIL;
            cmd_o.bw_data = (size_q[l_q] != '0) ? last_q[l_q] : NIL;
            if (size_q[l_q] == '0 || last_q[l_q][NW-1]) first_d[l_q] = ftop_q;
            else nb_d = last_q[l_q];
            last_d[l_q] = ftop_q; pos_d[l_q] = POS_ON;
          end
          2'd1: begin
            cmd_o.fw_data = first_q[l_q]; cmd_o.bw_data = NIL;
            nb_d = first_q[l_q];
            first_d[l_q] = ftop_q; pos_d[l_q] = POS_ON;
          end
          2'd2: begin
            cmd_o.fw_data = nb_q; cmd_o.bw_data = c;
          end
          default: begin
            cmd_o.fw_data = c; cmd_o.bw_data = nb_q;
          end
        endcase
        if (amode_q == 2'd0 && (size_q[l_q] == '0 || last_q[l_q][NW-1])) nb_d = NIL;
        walk_d = ftop_q;  // new node
      end
      S_ALLOC: begin
        // neighbor link fixes
        state_d = S_DONE;
        case (amode_q)
          2'd0: if (!nb_q[NW-1]) begin
            cmd_o.fw_en = 1'b1; cmd_o.fw_addr = nb_q[NA-1:0]; cmd_o.fw_data = walk_q;
          end
          2'd1: begin
            cmd_o.bw_en = 1'b1; cmd_o.bw_addr = nb_q[NA-1:0]; cmd_o.bw_data = walk_q;
          end
          2'd2: begin
            cmd_o.fw_en = 1'b1; cmd_o.fw_addr = c[NA-1:0]; cmd_o.fw_data = walk_q;
            cmd_o.bw_en = 1'b1; cmd_o.bw_addr = nb_q[NA-1:0]; cmd_o.bw_data = walk_q;
            cur_d[l_q] = walk_q;
          end
          default: begin
            cmd_o.fw_en = 1'b1; cmd_o.fw_addr = nb_q[NA-1:0]; cmd_o.fw_data = walk_q;
            cmd_o.bw_en = 1'b1; cmd_o.bw_addr = c[NA-1:0]; cmd_o.bw_data = walk_q;
            cur_d[l_q] = walk_q;
          end
        endcase
      end
      S_UNL: begin
        state_d = S_ALLOC;
        amode_d = 2'd0;
        rit_d = sts_i.value;
        if (!sts_i.bwd[NW-1]) begin
          cmd_o.fw_en = 1'b1; cmd_o.fw_addr = sts_i.bwd[NA-1:0];
          cmd_o.fw_data = sts_i.fwd;
        end else first_d[l_q] = sts_i.fwd;
        if (!sts_i.fwd[NW-1]) begin
          cmd_o.bw_en = 1'b1; cmd_o.bw_addr = sts_i.fwd[NA-1:0];
          cmd_o.bw_data = sts_i.bwd;
        end else last_d[l_q] = sts_i.bwd;
        // freed node pushed in the next cycle, in S_ALLOC, by the freed-node push below
        nb_d = c; walk_d = ftop_q; ftop_d = c;
        size_d[l_q] = size_q[l_q] - 1'b1;
        if (size_q[l_q] == CW'(1)) begin
          first_d[l_q] = NIL; last_d[l_q] = NIL; cur_d[l_q] = NIL;
          pos_d[l_q] = POS_ON;
        end else if (!sts_i.fwd[NW-1]) begin
          cur_d[l_q] = sts_i.fwd; pos_d[l_q] = POS_ON;
        end else begin
          cur_d[l_q] = sts_i.bwd; pos_d[l_q] = trim_q ? POS_ON : POS_BEYOND;
        end
        fn_d = F_REMOVE;
      end
      S_SRCH: begin
        if (sts_i.match) begin
          cur_d[l_q] = walk_q; pos_d[l_q] = POS_ON; rit_d = sts_i.value;
          state_d = S_DONE;
        end else if (sts_i.fwd[NW-1] || steps_q == (NA+1)'(NODES - 1)) begin
          cur_d[l_q] = last_q[l_q]; pos_d[l_q] = POS_BEYOND; rst_d = ST_NONE;
          state_d = S_DONE;
        end else begin
          walk_d = sts_i.fwd; steps_d = steps_q + 1'b1;
          cmd_o.rd_en = 1'b1; cmd_o.rd_addr = sts_i.fwd[NA-1:0];
        end
      end
      S_DONE: begin
        done_o = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // freed-node push after unlink: forward link of freed node to old top
    if (state_q == S_ALLOC && fn_q == F_REMOVE) begin
      cmd_o = '0;
      cmd_o.fw_en = 1'b1; cmd_o.fw_addr = nb_q[NA-1:0]; cmd_o.fw_data = walk_q;
      cmd_o.bw_en = 1'b1; cmd_o.bw_addr = nb_q[NA-1:0]; cmd_o.bw_data = NIL;
    end
  end

  always_comb begin
    status_o = rst_q;
    item_out_o = (rst_q == ST_OK) ? rit_q : '0;
    count_out_o = (rst_q == ST_DEAD || fn_q == F_CREATE) ? '0 : 7'(size_q[l_q]);
    new_list_o = (fn_q == F_CREATE) ? rnl_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < LISTS; i++) begin
        first_q[i] <= NIL; last_q[i] <= NIL; cur_q[i] <= NIL;
        size_q[i] <= '0; pos_q[i] <= POS_ON;
        hlink_q[i] <= (i + 1 < LISTS) ? LW'(i + 1) : {LW{1'b1}};
      end
      live_q <= '0;
      ftop_q <= '0; htop_q <= '0; lused_q <= '0; icnt_q <= '0;
      fn_q <= F_COUNT; rst_q <= ST_OK;
    end else begin
      state_q <= state_d;
      first_q <= first_d; last_q <= last_d; cur_q <= cur_d; size_q <= size_d;
      pos_q <= pos_d; live_q <= live_d; hlink_q <= hlink_d;
      ftop_q <= ftop_d; htop_q <= htop_d; lused_q <= lused_d; icnt_q <= icnt_d;
      fn_q <= fn_d; rst_q <= rst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q <= l_d; l2_q <= l2_d; val_q <= val_d; amode_q <= amode_d;
    nb_q <= nb_d; walk_q <= walk_d; steps_q <= steps_d;
    rit_q <= rit_d; rnl_q <= rnl_d; trim_q <= trim_d;
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> state_q == S_IDLE) else $error("result not followed by idle");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted op did not start");
  a_lused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lused_q == LW'($countones(live_q))) else $error("list count mismatch");
endmodule

/* tb/sv/tb_pooled_linked_list_manager.sv */
// Testbench for pooled_linked_list_manager: directed and state-aware random list operations,
// each checked against an in-bench model of the node pool, list heads and cursors.
// Depends on plm_pkg and the design files.
module tb_pooled_linked_list_manager;
  timeunit 1ns;
  timeprecision 1ps;
  import plm_pkg::*;

  typedef struct {
    logic [3:0]  func;
    logic [3:0]  lid;
    logic [3:0]  lid2;
    logic [31:0] item;
    logic [31:0] key;
  } list_op_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] item;
    logic [6:0]  count;
    logic [3:0]  new_list;
  } list_res_t;

  localparam logic [LW-1:0] HEAD_NIL = {LW{1'b1}};
  localparam int unsigned   CYCLE_LIMIT = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  func_r = '0;
  logic [3:0]  lid_r = '0;
  logic [3:0]  lid2_r = '0;
  logic [31:0] item_r = '0;
  logic [31:0] key_r = '0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        strobe_o;
  logic [1:0]  status_o;
  logic [31:0] item_out_o;
  logic [6:0]  count_out_o;
  logic [3:0]  new_list_o;

  pooled_linked_list_manager dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .func_i(func_r), .list_id_i(lid_r), .other_list_id_i(lid2_r),
    .item_i(item_r), .search_key_i(key_r),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .strobe_o(strobe_o), .status_o(status_o), .item_out_o(item_out_o),
    .count_out_o(count_out_o), .new_list_o(new_list_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // model state
  logic [31:0]   nd_val [NODES];
  logic [NW-1:0] nd_fwd [NODES];
  logic [NW-1:0] nd_bwd [NODES];
  logic [NW-1:0] ls_first [LISTS];
  logic [NW-1:0] ls_last [LISTS];
  logic [NW-1:0] ls_cur [LISTS];
  logic [6:0]    ls_size [LISTS];
  logic [1:0]    ls_pos [LISTS];
  bit            ls_live [LISTS];
  logic [LW-1:0] head_link [LISTS];
  logic [NW-1:0] free_node;
  logic [LW-1:0] free_head;
  int            lists_used;
  logic [31:0]   match_mask;

  list_op_t  op_queue[$];
  list_res_t results_expected[$];
  int        gap_pct = 0;
  int        fails = 0;
  int        cycles = 0;

  function automatic void rebuild_pools();
    for (int i = 0; i < NODES; i++) begin
      nd_fwd[i] = (i + 1 < NODES) ? NW'(i + 1) : NIL;
      nd_bwd[i] = NIL;
    end
    for (int i = 0; i < LISTS; i++) head_link[i] = (i + 1 < LISTS) ? LW'(i + 1) : HEAD_NIL;
    free_node = '0;
    free_head = '0;
    lists_used = 0;
  endfunction

  function automatic void clear_head(int l);
    ls_first[l] = NIL;
    ls_last[l] = NIL;
    ls_cur[l] = NIL;
    ls_size[l] = '0;
    ls_pos[l] = POS_ON;
  endfunction

  function automatic logic [NW-1:0] take_node(logic [31:0] v, logic [NW-1:0] f,
                                              logic [NW-1:0] b);
    logic [NW-1:0] n;
    n = free_node;
    if (n >= NODES) return NIL;
    free_node = nd_fwd[n];
    nd_val[n] = v;
    nd_fwd[n] = f;
    nd_bwd[n] = b;
    return n;
  endfunction

  function automatic void release_head(int l);
    clear_head(l);
    ls_live[l] = 1'b0;
    head_link[l] = free_head;
    free_head = LW'(l);
    lists_used--;
  endfunction

  function automatic logic [1:0] add_tail(int l, logic [31:0] v);
    logic [NW-1:0] last, n;
    last = ls_last[l];
    n = take_node(v, NIL, (ls_size[l] != 0) ? last : NIL);
    if (n == NIL) return ST_FULL;
    if (ls_size[l] == 0 || last >= NODES) ls_first[l] = n;
    else nd_fwd[last] = n;
    ls_last[l] = n;
    ls_cur[l] = n;
    ls_pos[l] = POS_ON;
    ls_size[l]++;
    return ST_OK;
  endfunction

  function automatic logic [1:0] add_head(int l, logic [31:0] v);
    logic [NW-1:0] first, n;
    first = ls_first[l];
    if (ls_size[l] == 0 || first >= NODES) return add_tail(l, v);
    n = take_node(v, first, NIL);
    if (n == NIL) return ST_FULL;
    nd_bwd[first] = n;
    ls_first[l] = n;
    ls_cur[l] = n;
    ls_pos[l] = POS_ON;
    ls_size[l]++;
    return ST_OK;
  endfunction

  function automatic logic [31:0] unlink_current(int l, bit trim);
    logic [NW-1:0] c, f, b;
    logic [31:0] v;
    c = ls_cur[l];
    v = nd_val[c];
    f = nd_fwd[c];
    b = nd_bwd[c];
    if (b < NODES) nd_fwd[b] = f; else ls_first[l] = f;
    if (f < NODES) nd_bwd[f] = b; else ls_last[l] = b;
    nd_fwd[c] = free_node;
    nd_bwd[c] = NIL;
    free_node = c;
    ls_size[l]--;
    if (ls_size[l] == 0) clear_head(l);
    else if (f < NODES) begin
      ls_cur[l] = f;
      ls_pos[l] = POS_ON;
    end else begin
      ls_cur[l] = b;
      ls_pos[l] = trim ? POS_ON : POS_BEYOND;
    end
    return v;
  endfunction

  function automatic list_res_t apply_list_op(list_op_t op);
    list_res_t r;
    int l, l2;
    logic [NW-1:0] c, n, f, b, t, h;
    logic [31:0] it;
    logic [1:0] st;
    r = '{ST_OK, '0, '0, '0};
    l = op.lid;
    l2 = op.lid2;
    st = ST_OK;
    it = '0;
    if (op.func == F_CREATE) begin
      if (lists_used == 0) rebuild_pools();
      if (free_head >= LISTS) r.status = ST_FULL;
      else begin
        n = NW'(free_head);
        free_head = head_link[n];
        clear_head(n);
        ls_live[n] = 1'b1;
        lists_used++;
        r.new_list = n[3:0];
      end
      return r;
    end
    if (!ls_live[l] || (op.func == F_CONCAT && !ls_live[l2])) begin
      r.status = ST_DEAD;
      return r;
    end
    c = ls_cur[l];
    case (op.func)
      F_COUNT: ;
      F_FIRST, F_LAST: begin
        n = (op.func == F_FIRST) ? ls_first[l] : ls_last[l];
        if (ls_size[l] == 0 || n >= NODES) st = ST_NONE;
        else begin
          ls_cur[l] = n;
          ls_pos[l] = POS_ON;
          it = nd_val[n];
        end
      end
      F_NEXT, F_PREV: begin
        if (c >= NODES) st = ST_NONE;
        else begin
          n = (op.func == F_NEXT) ? nd_fwd[c] : nd_bwd[c];
          if (ls_pos[l] == POS_ON && n < NODES) begin
            ls_cur[l] = n;
            it = nd_val[n];
          end else if (ls_pos[l] == ((op.func == F_NEXT) ? POS_BEFORE : POS_BEYOND)) begin
            ls_pos[l] = POS_ON;
            it = nd_val[c];
          end else begin
            ls_pos[l] = (op.func == F_NEXT) ? POS_BEYOND : POS_BEFORE;
            st = ST_NONE;
          end
        end
      end
      F_CURR: begin
        if (c >= NODES || ls_pos[l] != POS_ON) st = ST_NONE;
        else it = nd_val[c];
      end
      F_ADD, F_INSERT: begin
        if (free_node >= NODES) st = ST_FULL;
        else if (ls_pos[l] == POS_BEYOND) st = add_tail(l, op.item);
        else if (ls_pos[l] == POS_BEFORE) st = add_head(l, op.item);
        else if (ls_size[l] == 0 || c >= NODES) st = add_tail(l, op.item);
        else if (op.func == F_ADD) begin
          f = nd_fwd[c];
          if (f >= NODES) st = add_tail(l, op.item);
          else begin
            n = take_node(op.item, f, c);
            nd_fwd[c] = n;
            nd_bwd[f] = n;
            ls_cur[l] = n;
            ls_size[l]++;
          end
        end else begin
          b = nd_bwd[c];
          if (b >= NODES) st = add_head(l, op.item);
          else begin
            n = take_node(op.item, c, b);
            nd_fwd[b] = n;
            nd_bwd[c] = n;
            ls_cur[l] = n;
            ls_size[l]++;
          end
        end
      end
      F_APPEND: st = add_tail(l, op.item);
      F_PREPND: st = add_head(l, op.item);
      F_REMOVE: begin
        if (ls_size[l] == 0 || c >= NODES || ls_pos[l] != POS_ON) st = ST_NONE;
        else it = unlink_current(l, 1'b0);
      end
      F_CONCAT: begin
        if (l2 == l) st = ST_NONE;
        else begin
          if (ls_size[l2] != 0) begin
            if (ls_size[l] == 0) begin
              ls_first[l] = ls_first[l2];
              ls_last[l] = ls_last[l2];
              ls_cur[l] = ls_cur[l2];
              ls_size[l] = ls_size[l2];
              ls_pos[l] = ls_pos[l2];
            end else begin
              t = ls_last[l];
              h = ls_first[l2];
              if (t < NODES) nd_fwd[t] = h;
              if (h < NODES) nd_bwd[h] = t;
              ls_last[l] = ls_last[l2];
              ls_size[l] += ls_size[l2];
              if (ls_pos[l] == POS_BEYOND) ls_cur[l] = ls_last[l];
            end
          end
          release_head(l2);
        end
      end
      F_FREE: begin
        if (ls_size[l] != 0 && ls_last[l] < NODES) begin
          nd_fwd[ls_last[l]] = free_node;
          free_node = ls_first[l];
        end
        release_head(l);
      end
      F_TRIM: begin
        n = ls_last[l];
        if (ls_size[l] == 0 || n >= NODES) st = ST_NONE;
        else begin
          ls_cur[l] = n;
          ls_pos[l] = POS_ON;
          it = unlink_current(l, 1'b1);
        end
      end
      default: begin  // search from the cursor item
        if (c >= NODES || ls_pos[l] == POS_BEYOND) st = ST_NONE;
        else begin
          st = ST_NONE;
          n = c;
          for (int k = 0; k < NODES && n < NODES; k++) begin
            if (((nd_val[n] ^ op.key) & match_mask) == 0) begin
              ls_cur[l] = n;
              ls_pos[l] = POS_ON;
              it = nd_val[n];
              st = ST_OK;
              break;
            end
            n = nd_fwd[n];
          end
          if (st != ST_OK) begin
            ls_cur[l] = ls_last[l];
            ls_pos[l] = POS_BEYOND;
          end
        end
      end
    endcase
    r.status = st;
    r.item = (st == ST_OK) ? it : '0;
    r.count = ls_size[l];
    return r;
  endfunction

  // driver: one transaction in flight on the command port
  always @(posedge clk_i or negedge rst_ni) begin
    list_op_t op;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        results_expected.push_back(apply_list_op('{func_r, lid_r, lid2_r, item_r, key_r}));
      if (!start || !busy) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
          op = op_queue.pop_front();
          func_r <= op.func;
          lid_r <= op.lid;
          lid2_r <= op.lid2;
          item_r <= op.item;
          key_r <= op.key;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    list_res_t e;
    if (rst_ni && strobe_o) begin
      if (results_expected.size() == 0) begin
        $error("unexpected result, status %0d", status_o);
        fails++;
      end else begin
        e = results_expected.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, status_o);
          fails++;
        end
        if (item_out_o !== e.item) begin
          $error("item_out: expected %h actual %h", e.item, item_out_o);
          fails++;
        end
        if (count_out_o !== e.count) begin
          $error("count_out: expected %0d actual %0d", e.count, count_out_o);
          fails++;
        end
        if (new_list_o !== e.new_list) begin
          $error("new_list: expected %0d actual %0d", e.new_list, new_list_o);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic list_op_t mk(logic [3:0] f, logic [3:0] l, logic [3:0] l2,
                                  logic [31:0] it, logic [31:0] k);
    list_op_t op;
    op = '{f, l, l2, it, k};
    return op;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3:       return '0;
      4:       return '1;
      default: return {16'($urandom_range(3)), 16'($urandom_range(3))};
    endcase
  endfunction

  // random op aimed mostly at live lists
  function automatic list_op_t rand_op();
    int live_ids[$];
    int w;
    list_op_t op;
    for (int i = 0; i < LISTS; i++) if (ls_live[i]) live_ids.push_back(i);
    op = mk(F_COUNT, $urandom_range(15), $urandom_range(15), pick_value(), pick_value());
    if (live_ids.size() != 0 && $urandom_range(99) >= 8) begin
      op.lid = live_ids[$urandom_range(live_ids.size() - 1)];
      if ($urandom_range(3) != 0) op.lid2 = live_ids[$urandom_range(live_ids.size() - 1)];
    end
    w = $urandom_range(99);
    if (live_ids.size() == 0 || w < 7) op.func = F_CREATE;
    else if (w < 10) op.func = F_FREE;
    else if (w < 15) op.func = F_CONCAT;
    else if (w < 28) op.func = F_APPEND;
    else if (w < 34) op.func = F_PREPND;
    else if (w < 41) op.func = F_ADD;
    else if (w < 48) op.func = F_INSERT;
    else if (w < 75) op.func = 4'($urandom_range(F_FIRST, F_CURR));
    else if (w < 82) op.func = F_REMOVE;
    else if (w < 86) op.func = F_TRIM;
    else if (w < 96) op.func = F_SEARCH;
    else op.func = F_COUNT;
    return op;
  endfunction

  task automatic wait_idle();
    while (op_queue.size() != 0 || start || results_expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_mask(logic [31:0] v);
    wait_idle();
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    match_mask = v;
  endtask

  initial begin
    logic [31:0] masks [3];
    int pcts [3];
    for (int i = 0; i < NODES; i++) nd_val[i] = '0;
    for (int i = 0; i < LISTS; i++) begin
      clear_head(i);
      ls_live[i] = 1'b0;
    end
    rebuild_pools();
    match_mask = '1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty list, ends of the cursor, extremes, concat and dead-list cases
    op_queue.push_back(mk(F_CREATE, 0, 0, 0, 0));
    op_queue.push_back(mk(F_PREV, 0, 0, 0, 0));
    op_queue.push_back(mk(F_CURR, 0, 0, 0, 0));
    op_queue.push_back(mk(F_APPEND, 0, 0, 32'h0, 0));
    op_queue.push_back(mk(F_APPEND, 0, 0, 32'hFFFF_FFFF, 0));
    op_queue.push_back(mk(F_PREPND, 0, 0, 32'h5A5A_A5A5, 0));
    op_queue.push_back(mk(F_FIRST, 0, 0, 0, 0));
    op_queue.push_back(mk(F_NEXT, 0, 0, 0, 0));
    op_queue.push_back(mk(F_NEXT, 0, 0, 0, 0));
    op_queue.push_back(mk(F_NEXT, 0, 0, 0, 0));
    op_queue.push_back(mk(F_PREV, 0, 0, 0, 0));
    op_queue.push_back(mk(F_INSERT, 0, 0, 32'h1234_5678, 0));
    op_queue.push_back(mk(F_ADD, 0, 0, 32'h8765_4321, 0));
    op_queue.push_back(mk(F_FIRST, 0, 0, 0, 0));
    op_queue.push_back(mk(F_SEARCH, 0, 0, 0, 32'hFFFF_FFFF));
    op_queue.push_back(mk(F_REMOVE, 0, 0, 0, 0));
    op_queue.push_back(mk(F_TRIM, 0, 0, 0, 0));
    op_queue.push_back(mk(F_CREATE, 0, 0, 0, 0));
    op_queue.push_back(mk(F_CONCAT, 0, 1, 0, 0));
    op_queue.push_back(mk(F_CONCAT, 0, 0, 0, 0));
    op_queue.push_back(mk(F_COUNT, 15, 0, 0, 0));
    op_queue.push_back(mk(F_CREATE, 0, 0, 0, 0));
    op_queue.push_back(mk(F_CONCAT, 1, 0, 0, 0));
    op_queue.push_back(mk(F_FREE, 1, 0, 0, 0));
    op_queue.push_back(mk(F_CREATE, 0, 0, 0, 0));

    masks = '{32'h0, $urandom | 32'h0001_0000, 32'hFFFF_FFFF};
    pcts = '{20, 82, 0};
    for (int p = 0; p < 3; p++) begin
      write_mask(masks[p]);
      gap_pct = pcts[p];
      for (int i = 0; i < 570; i++) begin
        while (op_queue.size() != 0) @(posedge clk_i);
        op_queue.push_back(rand_op());
      end
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
